FILE: hdl/vcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcb_pkg
// Shared widths, codes and controller/datapath handshake types of the
// vector clock barrier release core.
// ----------------------------------------------------------------------------
package vcb_pkg;

  // field and register widths
  localparam int CLK_W      = 31;
  localparam int WORD_W     = 32;
  localparam int CLIENT_W   = 4;
  localparam int TABLE_W    = 3;
  localparam int CCNT_W     = 5;
  localparam int TCNT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int ERR_W      = 2;
  localparam int REM_W      = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT  = 1'b1;

  // result error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SEQ   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear;       // clearing sweep write
    logic accept;      // capture item, read its clock and table clock
    logic store;       // write the new client clock
    logic scan_start;  // reset minimum search
    logic scan_issue;  // read next client clock for the minimum
    logic decide;      // write table clock, start modulo, reset counter
    logic mod_step;    // one remainder bit
    logic rel_read;    // read clock of the next released client
    logic load_err;    // load error result
    logic load_rel;    // load release result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic range_err;
    logic seq_err;
    logic cnt_last;
    logic release_due;
    logic mod_done;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/vector_clock_barrier_release_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_clock_barrier_release_core
// Per-table vector clock barrier: checks each client clock report, keeps the
// table minimum and releases every client when that minimum advances.
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o   | client_num, report_clock, table_num
//   out     | out_valid_o / out_stall_i | target_client, barrier_clock,
//           |                           | client_own_clock, table_out,
//           |                           | last_of_run, error_code
//   cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// a checked item scans the clock memory for the minimum of its table, one read
// per cycle over the N client clocks (N = client count); a releasing item adds
// a bit-serial remainder and one clock memory read per release result
// after reset a clearing sweep over all clock memory entries,
// 2**(clog2(MAX_TABLES) + clog2(MAX_CLIENTS)) of them (128 at defaults), runs
// with in_stall_o high
// a full output register stalls the release run; the next item is taken
// while the last result still waits
// ----------------------------------------------------------------------------
module vector_clock_barrier_release_core #(
  parameter int MAX_CLIENTS = 16,
  parameter int MAX_TABLES  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vcb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vcb_pkg::CLIENT_W-1:0]   client_num_i,
  input  logic [vcb_pkg::CLK_W-1:0]      report_clock_i,
  input  logic [vcb_pkg::TABLE_W-1:0]    table_num_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vcb_pkg::CLIENT_W-1:0]   target_client_o,
  output logic [vcb_pkg::CLK_W-1:0]      barrier_clock_o,
  output logic [vcb_pkg::CLK_W-1:0]      client_own_clock_o,
  output logic [vcb_pkg::TABLE_W-1:0]    table_out_o,
  output logic                           last_of_run_o,
  output logic [vcb_pkg::ERR_W-1:0]      error_code_o
);

  vcb_pkg::cmd_t    cmd;
  vcb_pkg::status_t st;

  // sequencer
  vcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // stores, arithmetic and output register
  vcb_datapath #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .MAX_TABLES  (MAX_TABLES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .client_num_i       (client_num_i),
    .report_clock_i     (report_clock_i),
    .table_num_i        (table_num_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .target_client_o    (target_client_o),
    .barrier_clock_o    (barrier_clock_o),
    .client_own_clock_o (client_own_clock_o),
    .table_out_o        (table_out_o),
    .last_of_run_o      (last_of_run_o),
    .error_code_o       (error_code_o),
    .cmd_i              (cmd),
    .st_o               (st)
  );

endmodule

FILE: hdl/vcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/vcb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcb_ctrl
// Sequencer of the barrier core: clearing sweep, clock check, minimum scan,
// remainder for the release start and the release run.
// ----------------------------------------------------------------------------
module vcb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vcb_pkg::status_t st_i,
  output vcb_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b00_0000_0001,
    S_IDLE     = 10'b00_0000_0010,
    S_LOOKUP   = 10'b00_0000_0100,
    S_ERR      = 10'b00_0000_1000,
    S_SCAN     = 10'b00_0001_0000,
    S_SCAN_END = 10'b00_0010_0000,
    S_DECIDE   = 10'b00_0100_0000,
    S_MOD      = 10'b00_1000_0000,
    S_REL_RD   = 10'b01_0000_0000,
    S_REL_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st_i.range_err || st_i.seq_err) begin
          state_d = S_ERR;
        end else begin
          cmd_o.store      = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_ERR: begin
        if (st_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (st_i.release_due) begin
          cmd_o.decide = 1'b1;
          state_d      = S_MOD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (st_i.mod_done) begin
          state_d = S_REL_RD;
        end
      end
      S_REL_RD: begin
        cmd_o.rel_read = 1'b1;
        state_d        = S_REL_OUT;
      end
      S_REL_OUT: begin
        if (st_i.out_free) begin
          cmd_o.load_rel = 1'b1;
          state_d        = st_i.cnt_last ? S_IDLE : S_REL_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: hdl/vcb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcb_datapath
// Configuration registers, clock stores, minimum search, serial remainder,
// release cursor and output register of the barrier core.
// ----------------------------------------------------------------------------
module vcb_datapath #(
  parameter int MAX_CLIENTS = 16,
  parameter int MAX_TABLES  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vcb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vcb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [vcb_pkg::CLIENT_W-1:0]      client_num_i,
  input  logic [vcb_pkg::CLK_W-1:0]         report_clock_i,
  input  logic [vcb_pkg::TABLE_W-1:0]       table_num_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vcb_pkg::CLIENT_W-1:0]      target_client_o,
  output logic [vcb_pkg::CLK_W-1:0]         barrier_clock_o,
  output logic [vcb_pkg::CLK_W-1:0]         client_own_clock_o,
  output logic [vcb_pkg::TABLE_W-1:0]       table_out_o,
  output logic                              last_of_run_o,
  output logic [vcb_pkg::ERR_W-1:0]         error_code_o,
  input  vcb_pkg::cmd_t                     cmd_i,
  output vcb_pkg::status_t                  st_o
);

  localparam int CW     = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int TW     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int AW     = TW + CW;
  localparam int NcCap  = (MAX_CLIENTS < 31) ? MAX_CLIENTS : 31;
  localparam int NtCap  = (MAX_TABLES < 15) ? MAX_TABLES : 15;
  localparam int MsbIdx = vcb_pkg::CLK_W - 1;

  localparam logic [vcb_pkg::CCNT_W-1:0] NC_CAP  = NcCap[vcb_pkg::CCNT_W-1:0];
  localparam logic [vcb_pkg::TCNT_W-1:0] NT_CAP  = NtCap[vcb_pkg::TCNT_W-1:0];
  localparam logic [vcb_pkg::CCNT_W-1:0] MOD_TOP = MsbIdx[vcb_pkg::CCNT_W-1:0];
  localparam logic [AW-1:0]              CLR_END = {AW{1'b1}};

  // configuration registers
  logic [vcb_pkg::CCNT_W-1:0] clients_q;
  logic [vcb_pkg::TCNT_W-1:0] tables_q;
  logic [vcb_pkg::CCNT_W-1:0] nc;
  logic [vcb_pkg::TCNT_W-1:0] nt;

  // item capture
  logic [vcb_pkg::CLIENT_W-1:0] who_q;
  logic [vcb_pkg::CLK_W-1:0]    clk_q;
  logic [vcb_pkg::TABLE_W-1:0]  tab_q;
  logic                         range_err_q;
  logic                         range_err_d;

  // scan, remainder and release state
  logic [vcb_pkg::CCNT_W-1:0] idx_q;
  logic [vcb_pkg::CLK_W-1:0]  min_q;
  logic                       all_clk_q;
  logic                       issue_q;
  logic [vcb_pkg::CCNT_W-1:0] mod_cnt_q;
  logic [vcb_pkg::REM_W-1:0]  rem_q;
  logic [vcb_pkg::REM_W-1:0]  nc_ext;
  logic [vcb_pkg::REM_W-1:0]  rem_sh;
  logic [vcb_pkg::REM_W-1:0]  rem_mod_d;
  logic [vcb_pkg::REM_W-1:0]  rem_rel_d;
  logic [AW-1:0]              clr_cnt_q;

  // memory ports
  logic                        cl_we;
  logic [AW-1:0]               cl_waddr;
  logic [vcb_pkg::WORD_W-1:0]  cl_wdata;
  logic                        cl_re;
  logic [AW-1:0]               cl_raddr;
  logic [vcb_pkg::WORD_W-1:0]  cl_rdata;
  logic                        gl_we;
  logic [TW-1:0]               gl_waddr;
  logic [vcb_pkg::WORD_W-1:0]  gl_wdata;
  logic [vcb_pkg::WORD_W-1:0]  gl_rdata;

  // output register
  logic                         out_valid_q;
  logic [vcb_pkg::CLIENT_W-1:0] target_q;
  logic [vcb_pkg::CLK_W-1:0]    age_q;
  logic [vcb_pkg::CLK_W-1:0]    own_q;
  logic [vcb_pkg::TABLE_W-1:0]  tab_out_q;
  logic                         last_q;
  logic [vcb_pkg::ERR_W-1:0]    err_q;

  // effective counts: zero acts as one, large values clamp
  always_comb begin
    if (clients_q == '0) begin
      nc = {{(vcb_pkg::CCNT_W-1){1'b0}}, 1'b1};
    end else if (clients_q > NC_CAP) begin
      nc = NC_CAP;
    end else begin
      nc = clients_q;
    end
    if (tables_q == '0) begin
      nt = {{(vcb_pkg::TCNT_W-1){1'b0}}, 1'b1};
    end else if (tables_q > NT_CAP) begin
      nt = NT_CAP;
    end else begin
      nt = tables_q;
    end
  end

  assign range_err_d = ({1'b0, client_num_i} >= nc) || ({1'b0, table_num_i} >= nt);

  // client clock store: {clocked, clock} per table and client
  assign cl_we    = cmd_i.clear | cmd_i.store;
  assign cl_waddr = cmd_i.clear ? clr_cnt_q : {TW'(tab_q), CW'(who_q)};
  assign cl_wdata = cmd_i.clear ? '0 : {1'b1, clk_q};
  assign cl_re    = cmd_i.accept | cmd_i.scan_issue | cmd_i.rel_read;

  always_comb begin
    if (cmd_i.accept) begin
      cl_raddr = {TW'(table_num_i), CW'(client_num_i)};
    end else if (cmd_i.scan_issue) begin
      cl_raddr = {TW'(tab_q), CW'(idx_q)};
    end else begin
      cl_raddr = {TW'(tab_q), CW'(rem_q)};
    end
  end

  vcb_ram #(
    .WIDTH (vcb_pkg::WORD_W),
    .DEPTH (2 ** AW)
  ) u_client_ram (
    .clk_i   (clk_i),
    .we_i    (cl_we),
    .waddr_i (cl_waddr),
    .wdata_i (cl_wdata),
    .re_i    (cl_re),
    .raddr_i (cl_raddr),
    .rdata_o (cl_rdata)
  );

  // table clock store: {valid, clock} per table
  assign gl_we    = (cmd_i.clear && (clr_cnt_q[AW-1:TW] == '0)) | cmd_i.decide;
  assign gl_waddr = cmd_i.clear ? clr_cnt_q[TW-1:0] : TW'(tab_q);
  assign gl_wdata = cmd_i.clear ? '0 : {1'b1, min_q};

  vcb_ram #(
    .WIDTH (vcb_pkg::WORD_W),
    .DEPTH (2 ** TW)
  ) u_global_ram (
    .clk_i   (clk_i),
    .we_i    (gl_we),
    .waddr_i (gl_waddr),
    .wdata_i (gl_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (TW'(table_num_i)),
    .rdata_o (gl_rdata)
  );

  // serial remainder of the minimum by the client count, and release cursor
  assign nc_ext    = {1'b0, nc};
  assign rem_sh    = {rem_q[vcb_pkg::REM_W-2:0], min_q[mod_cnt_q]};
  assign rem_mod_d = (rem_sh >= nc_ext) ? (rem_sh - nc_ext) : rem_sh;
  assign rem_rel_d = (rem_q == (nc_ext - 6'd1)) ? '0 : (rem_q + 6'd1);

  // status
  assign st_o.clr_done    = (clr_cnt_q == CLR_END);
  assign st_o.range_err   = range_err_q;
  assign st_o.seq_err     = cl_rdata[vcb_pkg::CLK_W] &&
                            ({1'b0, clk_q} != ({1'b0, cl_rdata[vcb_pkg::CLK_W-1:0]} + 32'd1));
  assign st_o.cnt_last    = (idx_q == (nc - 5'd1));
  assign st_o.release_due = all_clk_q &&
                            !(gl_rdata[vcb_pkg::CLK_W] &&
                              (gl_rdata[vcb_pkg::CLK_W-1:0] == min_q));
  assign st_o.mod_done    = (mod_cnt_q == '0);
  assign st_o.out_free    = !out_valid_q || !out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clients_q   <= 5'd1;
      tables_q    <= 4'd1;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vcb_pkg::REG_CLIENT_COUNT: clients_q <= cfg_data_i;
          vcb_pkg::REG_TABLE_COUNT:  tables_q  <= cfg_data_i[vcb_pkg::TCNT_W-1:0];
          default: ;
        endcase
      end
      issue_q <= cmd_i.scan_issue;
      if (cmd_i.load_err || cmd_i.load_rel) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // item capture, minimum search, remainder and release cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      who_q       <= client_num_i;
      clk_q       <= report_clock_i;
      tab_q       <= table_num_i;
      range_err_q <= range_err_d;
    end
    if (cmd_i.scan_start) begin
      idx_q     <= '0;
      min_q     <= '1;
      all_clk_q <= 1'b1;
    end
    if (cmd_i.scan_issue) begin
      idx_q <= idx_q + 5'd1;
    end
    if (issue_q) begin
      all_clk_q <= all_clk_q & cl_rdata[vcb_pkg::CLK_W];
      if (cl_rdata[vcb_pkg::CLK_W-1:0] < min_q) begin
        min_q <= cl_rdata[vcb_pkg::CLK_W-1:0];
      end
    end
    if (cmd_i.decide) begin
      rem_q     <= '0;
      mod_cnt_q <= MOD_TOP;
      idx_q     <= '0;
    end
    if (cmd_i.mod_step) begin
      rem_q     <= rem_mod_d;
      mod_cnt_q <= mod_cnt_q - 5'd1;
    end
    if (cmd_i.load_rel) begin
      rem_q <= rem_rel_d;
      idx_q <= idx_q + 5'd1;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      target_q  <= who_q;
      age_q     <= '0;
      own_q     <= '0;
      tab_out_q <= tab_q;
      last_q    <= 1'b1;
      err_q     <= range_err_q ? vcb_pkg::ERR_RANGE : vcb_pkg::ERR_SEQ;
    end else if (cmd_i.load_rel) begin
      target_q  <= rem_q[vcb_pkg::CLIENT_W-1:0];
      age_q     <= min_q;
      own_q     <= cl_rdata[vcb_pkg::CLK_W-1:0];
      tab_out_q <= tab_q;
      last_q    <= st_o.cnt_last;
      err_q     <= vcb_pkg::ERR_NONE;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign target_client_o    = target_q;
  assign barrier_clock_o    = age_q;
  assign client_own_clock_o = own_q;
  assign table_out_o        = tab_out_q;
  assign last_of_run_o      = last_q;
  assign error_code_o       = err_q;

endmodule
